// File: rtl/pbgs_pkg.sv
// ----------------------------------------------------------------------------
// pbgs_pkg
// shared types and constants of the pixel binning gain scaler
// ----------------------------------------------------------------------------
`default_nettype none

package pbgs_pkg;

   localparam int NUM_LANES = 3;
   localparam int SAMPLE_W  = 16;
   localparam int SUM_W     = 24;
   localparam int GAIN_W    = 20;
   localparam int PROD_W    = SUM_W + GAIN_W;
   localparam int X_W       = PROD_W + 1;
   localparam int Y_W       = X_W - 12;
   localparam int BIN_W     = 5;
   localparam int SQ_W      = 2 * BIN_W;
   localparam int COL_W     = 12;
   localparam int IDX_W     = 3;
   localparam int Q_W       = 8;
   localparam int STEP_W    = 3;

   localparam logic [IDX_W-1:0] REG_BIN_FACTOR     = 3'd0;
   localparam logic [IDX_W-1:0] REG_CHANNEL_SELECT = 3'd1;
   localparam logic [IDX_W-1:0] REG_MONO_INPUT     = 3'd2;
   localparam logic [IDX_W-1:0] REG_WIDE_INPUT     = 3'd3;
   localparam logic [IDX_W-1:0] REG_GAIN_RED       = 3'd4;
   localparam logic [IDX_W-1:0] REG_GAIN_GREEN     = 3'd5;
   localparam logic [IDX_W-1:0] REG_GAIN_BLUE      = 3'd6;

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample_red;
      logic [SAMPLE_W-1:0] sample_green;
      logic [SAMPLE_W-1:0] sample_blue;
      logic                end_of_line;
      logic                last_row;
   } req_type;

   typedef struct packed {
      logic [Q_W-1:0]   out_red;
      logic [Q_W-1:0]   out_green;
      logic [Q_W-1:0]   out_blue;
      logic [COL_W-1:0] out_column;
      logic             out_row_end;
   } rsp_type;

   // sequencing strobes shared by all lanes
   typedef struct packed {
      logic            rd_en;
      logic            clr_en;
      logic            upd_en;
      logic            emit;
      logic            mul_en;
      logic            add_en;
      logic            div_load;
      logic            div_step;
      logic            wide;
      logic [SQ_W-1:0] sq;
   } lane_ctrl_type;

endpackage

`default_nettype wire

// File: rtl/pixel_binning_gain_scaler_core.sv
// ----------------------------------------------------------------------------
// pixel_binning_gain_scaler_core
// bin-by-bin box filter downscaler with per-channel gain and saturation
// ----------------------------------------------------------------------------
// a request that completes no block passes through a memory read, then an update
// a completing request passes through read, update, multiply, round, divider
// load, 8 divider steps and a hand-over into the response register; the 8-bit
// restoring divide by bin squared takes the most steps; a response stall holds the hand-over
// after reset the accumulators are cleared one address a cycle over all
// MAX_LINE_WIDTH addresses, during which no request is taken
// ----------------------------------------------------------------------------
`default_nettype none

module pixel_binning_gain_scaler_core
   import pbgs_pkg::*;
#(
   parameter int MAX_LINE_WIDTH = 4096,
   parameter int MAX_BIN        = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire req_type           req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsp_type                rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [IDX_W-1:0]  csr_index,
   input  wire logic [GAIN_W-1:0] csr_data
);

   localparam int AW   = $clog2(MAX_LINE_WIDTH);
   localparam int PH_W = $clog2(MAX_BIN);
   localparam int CW   = PH_W + BIN_W;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_UPDATE, S_MUL, S_ADD, S_LOAD, S_DIV, S_DONE
   } state_type;

   // configuration registers
   logic [BIN_W-1:0]  bin_factor_ff;
   logic [1:0]        channel_select_ff;
   logic              mono_input_ff;
   logic              wide_input_ff;
   logic [GAIN_W-1:0] gain_ff [NUM_LANES];

   state_type         state_ff;
   logic [AW-1:0]     clr_cnt_ff;
   logic [STEP_W-1:0] step_ff;
   logic [PH_W-1:0]   column_phase_ff;
   logic [PH_W-1:0]   row_phase_ff;
   logic [COL_W-1:0]  output_column_ff;
   logic [COL_W-1:0]  emit_column_ff;
   logic              eol_ff;
   logic              last_ff;
   logic              emit_eol_ff;
   logic [SAMPLE_W-1:0] lane_sample_ff [NUM_LANES];

   logic               accept;
   logic [BIN_W-1:0]   bin_eff;
   logic [SQ_W-1:0]    bin_sq;
   logic               emit_row;
   logic               col_done;
   logic               emit;
   logic [AW+COL_W-1:0] col_ext;
   logic [AW-1:0]      addr;
   lane_ctrl_type      ctrl;
   logic [NUM_LANES-1:0][Q_W-1:0] lane_q;
   logic [1:0]         src [NUM_LANES];
   logic [SAMPLE_W-1:0] samp [NUM_LANES];
   logic               merge_free;
   logic               merge_load;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   // register writes, indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         bin_factor_ff     <= BIN_W'(1);
         channel_select_ff <= 2'd0;
         mono_input_ff     <= 1'b0;
         wide_input_ff     <= 1'b0;
         gain_ff[0]        <= GAIN_W'(4096);
         gain_ff[1]        <= GAIN_W'(4096);
         gain_ff[2]        <= GAIN_W'(4096);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_BIN_FACTOR:     bin_factor_ff     <= csr_data[BIN_W-1:0];
            REG_CHANNEL_SELECT: channel_select_ff <= csr_data[1:0];
            REG_MONO_INPUT:     mono_input_ff     <= csr_data[0];
            REG_WIDE_INPUT:     wide_input_ff     <= csr_data[0];
            REG_GAIN_RED:       gain_ff[0]        <= csr_data;
            REG_GAIN_GREEN:     gain_ff[1]        <= csr_data;
            REG_GAIN_BLUE:      gain_ff[2]        <= csr_data;
            default: ;
         endcase
      end
   end

   // bin of zero acts as one, anything above the ceiling is clamped
   always_comb begin
      if (bin_factor_ff == '0) begin
         bin_eff = BIN_W'(1);
      end else if (int'(bin_factor_ff) > MAX_BIN) begin
         bin_eff = BIN_W'(MAX_BIN);
      end else begin
         bin_eff = bin_factor_ff;
      end
   end
   assign bin_sq = {{BIN_W{1'b0}}, bin_eff} * {{BIN_W{1'b0}}, bin_eff};

   // source of each output channel; narrow samples keep their low byte
   assign samp[0] = wide_input_ff ? req_data.sample_red   : {8'd0, req_data.sample_red[7:0]};
   assign samp[1] = wide_input_ff ? req_data.sample_green : {8'd0, req_data.sample_green[7:0]};
   assign samp[2] = wide_input_ff ? req_data.sample_blue  : {8'd0, req_data.sample_blue[7:0]};

   for (genvar c = 0; c < NUM_LANES; c++) begin : g_src
      assign src[c] = (channel_select_ff == 2'd0) ? 2'(c) : channel_select_ff - 2'd1;
   end

   // a phase at or past bin-1 ends the block, so a mid-group bin change settles
   assign emit_row = ({{BIN_W{1'b0}}, row_phase_ff} + CW'(1) >= {{PH_W{1'b0}}, bin_eff})
                     || last_ff;
   assign col_done = ({{BIN_W{1'b0}}, column_phase_ff} + CW'(1) >= {{PH_W{1'b0}}, bin_eff})
                     || eol_ff;
   assign emit     = emit_row && col_done;

   assign col_ext = {{AW{1'b0}}, output_column_ff};
   assign addr    = (state_ff == S_CLEAR) ? clr_cnt_ff : col_ext[AW-1:0];

   always_comb begin
      ctrl          = '0;
      ctrl.wide     = wide_input_ff;
      ctrl.sq       = bin_sq;
      ctrl.rd_en    = accept;
      ctrl.clr_en   = (state_ff == S_CLEAR);
      ctrl.upd_en   = (state_ff == S_UPDATE);
      ctrl.emit     = emit;
      ctrl.mul_en   = (state_ff == S_MUL);
      ctrl.add_en   = (state_ff == S_ADD);
      ctrl.div_load = (state_ff == S_LOAD);
      ctrl.div_step = (state_ff == S_DIV);
   end

   assign merge_load = (state_ff == S_DONE);

   // sequencer, raster counters and latched request
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         clr_cnt_ff       <= '0;
         step_ff          <= '0;
         column_phase_ff  <= '0;
         row_phase_ff     <= '0;
         output_column_ff <= '0;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + AW'(1);
               if (clr_cnt_ff == AW'(MAX_LINE_WIDTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               emit_column_ff <= output_column_ff;
               emit_eol_ff    <= eol_ff;
               if (eol_ff) begin
                  column_phase_ff  <= '0;
                  output_column_ff <= '0;
                  row_phase_ff     <= emit_row ? '0 : row_phase_ff + PH_W'(1);
               end else if (col_done) begin
                  column_phase_ff  <= '0;
                  output_column_ff <= output_column_ff + COL_W'(1);
               end else begin
                  column_phase_ff  <= column_phase_ff + PH_W'(1);
               end
               state_ff <= emit ? S_MUL : S_IDLE;
            end
            S_MUL:  state_ff <= S_ADD;
            S_ADD:  state_ff <= S_LOAD;
            S_LOAD: begin
               step_ff  <= '0;
               state_ff <= S_DIV;
            end
            S_DIV: begin
               step_ff <= step_ff + STEP_W'(1);
               if (step_ff == {STEP_W{1'b1}}) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (merge_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_CLEAR;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         eol_ff  <= req_data.end_of_line;
         last_ff <= req_data.last_row;
         for (int c = 0; c < NUM_LANES; c++) begin
            lane_sample_ff[c] <= mono_input_ff ? samp[0] : samp[src[c]];
         end
      end
   end

   for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
      pbgs_lane #(
         .AW (AW)
      ) u_lane (
         .clock  (clock),
         .ctrl   (ctrl),
         .addr   (addr),
         .sample (lane_sample_ff[c]),
         .gain   (gain_ff[src[c]]),
         .q      (lane_q[c])
      );
   end

   pbgs_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (merge_load),
      .lane_q    (lane_q),
      .column    (emit_column_ff),
      .row_end   (emit_eol_ff),
      .free      (merge_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // one request in flight at a time
   assert property (@(posedge clock) disable iff (reset) accept |=> !req_ready)
      else $error("request taken while another is in flight");

   // no request during the clearing pass
   assert property (@(posedge clock) (state_ff == S_CLEAR) |-> !req_ready)
      else $error("request ready during accumulator clear");

   // a result is only handed over when the response register can take it
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && merge_free |=> rsp_valid)
      else $error("completed result lost at hand-over");

   // the divider runs exactly its eight steps before hand-over
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && $past(state_ff) != S_DONE |-> $past(step_ff) == {STEP_W{1'b1}})
      else $error("divider hand-over before last step");

endmodule

`default_nettype wire

// File: rtl/pbgs_lane.sv
// ----------------------------------------------------------------------------
// pbgs_lane
// one channel: line accumulator memory, gain multiply and bin divide
// ----------------------------------------------------------------------------
`default_nettype none

module pbgs_lane
   import pbgs_pkg::*;
#(
   parameter int AW = 12
) (
   input  wire logic                clock,
   input  wire lane_ctrl_type       ctrl,
   input  wire logic [AW-1:0]       addr,
   input  wire logic [SAMPLE_W-1:0] sample,
   input  wire logic [GAIN_W-1:0]   gain,
   output logic      [Q_W-1:0]      q
);

   logic [SUM_W-1:0]  mem [2**AW];
   logic [SUM_W-1:0]  rdata_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  sum_in;
   logic [SUM_W:0]    raw_sum;
   logic [PROD_W-1:0] prod_ff;
   logic [X_W-1:0]    half;
   logic [X_W-1:0]    x_sum;
   logic [Y_W-1:0]    y_ff;
   logic [Y_W-1:0]    y_in;
   logic [SQ_W-1:0]   rem_ff;
   logic [SQ_W:0]     trial;
   logic [Q_W-1:0]    bits_ff;
   logic [Q_W-1:0]    quo_ff;
   logic              sat_ff;

   assign raw_sum = {1'b0, rdata_ff} + {{(SUM_W+1-SAMPLE_W){1'b0}}, sample};
   assign sum_in  = raw_sum[SUM_W] ? {SUM_W{1'b1}} : raw_sum[SUM_W-1:0];

   // rounding offset is half the divisor, divisor = sq * 2^12 (* 2^8 wide)
   assign half  = ctrl.wide ? {{(X_W-SQ_W-19){1'b0}}, ctrl.sq, 19'd0}
                            : {{(X_W-SQ_W-11){1'b0}}, ctrl.sq, 11'd0};
   assign x_sum = {1'b0, prod_ff} + half;
   assign y_in  = ctrl.wide ? {8'd0, x_sum[X_W-1:20]} : x_sum[X_W-1:12];

   assign trial = {rem_ff, bits_ff[Q_W-1]};

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rdata_ff <= mem[addr];
      end
      if (ctrl.clr_en) begin
         mem[addr] <= '0;
      end else if (ctrl.upd_en) begin
         mem[addr] <= ctrl.emit ? '0 : sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.upd_en) begin
         sum_ff <= sum_in;
      end
      if (ctrl.mul_en) begin
         prod_ff <= sum_ff * gain;
      end
      if (ctrl.add_en) begin
         y_ff <= y_in;
      end
      if (ctrl.div_load) begin
         sat_ff  <= y_ff >= {{(Y_W-SQ_W-Q_W){1'b0}}, ctrl.sq, {Q_W{1'b0}}};
         rem_ff  <= y_ff[Q_W +: SQ_W];
         bits_ff <= y_ff[Q_W-1:0];
         quo_ff  <= '0;
      end else if (ctrl.div_step) begin
         // restoring divide, one quotient bit a cycle
         bits_ff <= {bits_ff[Q_W-2:0], 1'b0};
         if (trial >= {1'b0, ctrl.sq}) begin
            rem_ff <= SQ_W'(trial - {1'b0, ctrl.sq});
            quo_ff <= {quo_ff[Q_W-2:0], 1'b1};
         end else begin
            rem_ff <= trial[SQ_W-1:0];
            quo_ff <= {quo_ff[Q_W-2:0], 1'b0};
         end
      end
   end

   assign q = sat_ff ? {Q_W{1'b1}} : quo_ff;

endmodule

`default_nettype wire

// File: rtl/pbgs_merge.sv
// ----------------------------------------------------------------------------
// pbgs_merge
// gathers the lane bytes, column and row-end flag into the held response register
// ----------------------------------------------------------------------------
`default_nettype none

module pbgs_merge
   import pbgs_pkg::*;
(
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          load,
   input  wire logic [NUM_LANES-1:0][Q_W-1:0] lane_q,
   input  wire logic [COL_W-1:0]              column,
   input  wire logic                          row_end,
   output logic                               free,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output rsp_type                            rsp_data
);

   logic    valid_ff;
   rsp_type data_ff;

   assign free = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load && free) begin
         valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load && free) begin
         data_ff.out_red     <= lane_q[0];
         data_ff.out_green   <= lane_q[1];
         data_ff.out_blue    <= lane_q[2];
         data_ff.out_column  <= column;
         data_ff.out_row_end <= row_end;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

`default_nettype wire

// File: tb/pixel_binning_gain_scaler_core_tb.sv
// ----------------------------------------------------------------------------
// pixel_binning_gain_scaler_core_tb
// drives raster pixels through the binning scaler under several register
// settings and compares every binned rgb byte result with a local predictor
// ----------------------------------------------------------------------------
`default_nettype none

// holds the predicted binned pixels and checks the block's results against them
class binned_pixel_board;
   localparam int LINE_W = 4096;

   bit [23:0] sums [3*LINE_W];
   bit [11:0] out_col;
   bit [3:0]  col_ph;
   bit [3:0]  row_ph;

   bit [4:0]  bin_reg;
   bit [1:0]  chan_sel;
   bit        mono;
   bit        wide;
   bit [19:0] gain [3];

   pbgs_pkg::rsp_type pending [$];
   int errors;
   int matched;

   function void clear_all();
      foreach (sums[i]) sums[i] = '0;
      out_col = '0;
      col_ph  = '0;
      row_ph  = '0;
      bin_reg = 5'd1;
      chan_sel = '0;
      mono = 0;
      wide = 0;
      foreach (gain[i]) gain[i] = 20'd4096;
      errors = 0;
      matched = 0;
   endfunction

   function void write_reg(logic [2:0] idx, logic [19:0] val);
      case (idx)
         pbgs_pkg::REG_BIN_FACTOR:     bin_reg  = val[4:0];
         pbgs_pkg::REG_CHANNEL_SELECT: chan_sel = val[1:0];
         pbgs_pkg::REG_MONO_INPUT:     mono     = val[0];
         pbgs_pkg::REG_WIDE_INPUT:     wide     = val[0];
         pbgs_pkg::REG_GAIN_RED:       gain[0]  = val;
         pbgs_pkg::REG_GAIN_GREEN:     gain[1]  = val;
         pbgs_pkg::REG_GAIN_BLUE:      gain[2]  = val;
         default: ;
      endcase
   endfunction

   function bit [7:0] scale(bit [23:0] s, bit [19:0] g, int b);
      longint unsigned d, q;
      d = 64'd4096 * b * b;
      if (wide) d = d * 256;
      q = (longint'(s) * g + d / 2) / d;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   function void note_request(pbgs_pkg::req_type r);
      bit [15:0] samp [3];
      int src [3];
      int b, col;
      bit emit_row, col_done;
      longint unsigned acc;
      pbgs_pkg::rsp_type e;
      b = bin_reg;
      if (b < 1) b = 1;
      if (b > 16) b = 16;
      samp[0] = wide ? r.sample_red   : {8'd0, r.sample_red[7:0]};
      samp[1] = wide ? r.sample_green : {8'd0, r.sample_green[7:0]};
      samp[2] = wide ? r.sample_blue  : {8'd0, r.sample_blue[7:0]};
      col = out_col % LINE_W;
      for (int c = 0; c < 3; c++) begin
         src[c] = (chan_sel == 0) ? c : chan_sel - 1;
         acc = sums[c*LINE_W+col] + (mono ? samp[0] : samp[src[c]]);
         sums[c*LINE_W+col] = (acc > 24'hFFFFFF) ? 24'hFFFFFF : acc[23:0];
      end
      emit_row = (row_ph + 1 >= b) || r.last_row;
      col_done = (col_ph + 1 >= b) || r.end_of_line;
      if (emit_row && col_done) begin
         e.out_red   = scale(sums[col], gain[src[0]], b);
         e.out_green = scale(sums[LINE_W+col], gain[src[1]], b);
         e.out_blue  = scale(sums[2*LINE_W+col], gain[src[2]], b);
         for (int c = 0; c < 3; c++) sums[c*LINE_W+col] = '0;
         e.out_column  = out_col;
         e.out_row_end = r.end_of_line;
         pending.push_back(e);
      end
      if (r.end_of_line) begin
         col_ph = 0;
         out_col = 0;
         row_ph = emit_row ? 4'd0 : row_ph + 1;
      end else if (col_done) begin
         col_ph = 0;
         out_col = out_col + 1;
      end else begin
         col_ph = col_ph + 1;
      end
   endfunction

   function void check_result(pbgs_pkg::rsp_type a);
      pbgs_pkg::rsp_type e;
      if (pending.size() == 0) begin
         $error("unexpected result %p", a);
         errors++;
         return;
      end
      e = pending.pop_front();
      matched++;
      if (a.out_red != e.out_red) begin
         $error("out_red expected %0d actual %0d", e.out_red, a.out_red);
         errors++;
      end
      if (a.out_green != e.out_green) begin
         $error("out_green expected %0d actual %0d", e.out_green, a.out_green);
         errors++;
      end
      if (a.out_blue != e.out_blue) begin
         $error("out_blue expected %0d actual %0d", e.out_blue, a.out_blue);
         errors++;
      end
      if (a.out_column != e.out_column) begin
         $error("out_column expected %0d actual %0d", e.out_column, a.out_column);
         errors++;
      end
      if (a.out_row_end != e.out_row_end) begin
         $error("out_row_end expected %0d actual %0d", e.out_row_end, a.out_row_end);
         errors++;
      end
   endfunction
endclass

module pixel_binning_gain_scaler_core_tb;
   import pbgs_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_type rsp_data;
   logic csr_valid = 0;
   logic csr_ready;
   logic [IDX_W-1:0] csr_index = '0;
   logic [GAIN_W-1:0] csr_data = '0;

   binned_pixel_board board;
   int requests_sent;
   int csr_writes;
   bit sender_done;

   pixel_binning_gain_scaler_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // mostly short gaps, now and then a long one
   function int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // results are sampled at the rising edge, ready changes at the falling edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
   end

   initial begin
      int g;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_ready <= 0;
         end else begin
            g = gap_len();
            if (g == 0) begin
               rsp_ready <= 1;
            end else begin
               rsp_ready <= 0;
               repeat (g - 1) @(negedge clock);
            end
         end
      end
   end

   task automatic write_csr(logic [IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      csr_valid <= 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, val);
      csr_writes++;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   // request stays up until accepted, payload held
   task automatic send_pixel(req_type r);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(r);
      requests_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      // a completing request runs through multiply, round and divide; leave margin for trailers
      repeat (40) @(negedge clock);
   endtask

   function req_type rand_pixel(bit eol, bit last);
      req_type r;
      r.sample_red   = 16'($urandom);
      r.sample_green = 16'($urandom);
      r.sample_blue  = 16'($urandom);
      if ($urandom_range(0, 7) == 0) r.sample_red = 16'hFFFF;
      if ($urandom_range(0, 7) == 0) r.sample_green = 16'h0000;
      r.end_of_line = eol;
      r.last_row = last;
      return r;
   endfunction

   // one image of the given size in raster order
   task automatic send_image(int width, int height);
      for (int y = 0; y < height; y++)
         for (int x = 0; x < width; x++)
            send_pixel(rand_pixel(x == width - 1, y == height - 1));
   endtask

   task automatic random_settings();
      write_csr(REG_BIN_FACTOR, GAIN_W'($urandom_range(0, 31) < 4 ?
                $urandom_range(0, 31) : $urandom_range(1, 5)));
      write_csr(REG_CHANNEL_SELECT, GAIN_W'($urandom_range(0, 3)));
      write_csr(REG_MONO_INPUT, GAIN_W'($urandom_range(0, 1)));
      write_csr(REG_WIDE_INPUT, GAIN_W'($urandom_range(0, 1)));
      write_csr(REG_GAIN_RED, GAIN_W'($urandom_range(0, 3) == 0 ?
                $urandom : $urandom_range(0, 16384)));
      write_csr(REG_GAIN_GREEN, GAIN_W'($urandom_range(0, 3) == 0 ?
                $urandom : $urandom_range(0, 16384)));
      write_csr(REG_GAIN_BLUE, GAIN_W'($urandom_range(0, 3) == 0 ?
                $urandom : $urandom_range(0, 16384)));
   endtask

   initial begin
      req_type r;
      int w, h;
      board = new();
      board.clear_all();
      requests_sent = 0;
      csr_writes = 0;
      sender_done = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: bin 1 extremes, then a 16-wide block with saturation
      r = '0; r.end_of_line = 1;
      send_pixel(r);
      r = '1;
      send_pixel(r);
      r = '0; r.sample_red = 16'h00FF; r.sample_green = 16'h8001;
      r.sample_blue = 16'h7F80; r.end_of_line = 1; r.last_row = 1;
      send_pixel(r);
      drain();
      write_csr(REG_BIN_FACTOR, 16);
      write_csr(REG_WIDE_INPUT, 1);
      write_csr(REG_GAIN_RED, 20'hFFFFF);
      write_csr(REG_GAIN_GREEN, 0);
      write_csr(REG_GAIN_BLUE, 1);
      send_image(3, 2);
      drain();
      // overlong bin and zero bin, mono and single channel modes
      write_csr(REG_BIN_FACTOR, 31);
      write_csr(REG_MONO_INPUT, 1);
      write_csr(REG_CHANNEL_SELECT, 3);
      send_image(2, 1);
      drain();
      write_csr(REG_BIN_FACTOR, 0);
      write_csr(REG_MONO_INPUT, 0);
      write_csr(REG_CHANNEL_SELECT, 2);
      write_csr(REG_WIDE_INPUT, 0);
      send_image(3, 1);
      drain();
      // bin change mid-group: one row under bin 4, then bin 2 ends the group
      write_csr(REG_BIN_FACTOR, 4);
      for (int x = 0; x < 5; x++)
         send_pixel(rand_pixel(x == 4, 1'b0));
      drain();
      write_csr(REG_BIN_FACTOR, 2);
      send_image(5, 2);
      drain();

      // random images under random settings
      while (requests_sent < 1150) begin
         random_settings();
         w = $urandom_range(1, 12);
         h = $urandom_range(1, 6);
         if ($urandom_range(0, 9) == 0) begin
            // broken raster: random marker bits
            for (int i = 0; i < w * h; i++)
               send_pixel(rand_pixel($urandom_range(0, 3) == 0, $urandom_range(0, 5) == 0));
         end else begin
            send_image(w, h);
         end
         drain();
      end
      sender_done = 1;
   end

   initial begin
      wait (sender_done);
      repeat (40) @(posedge clock);
      $display("sent %0d pixels and %0d register writes, checked %0d binned results",
               requests_sent, csr_writes, board.matched);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #10000000;
      $display("Test completed with failures");
      $finish;
   end
endmodule

`default_nettype wire
